>>> rtl/core/pstsch_pkg.sv
// Shared types and constants for the periodic slot tick scheduler.
// No dependencies; used by pstsch_cell and periodic_slot_tick_scheduler_core.
`default_nettype none

package pstsch_pkg;

  localparam int NUM_SLOTS   = 10;
  localparam int TICK_W      = 32;
  localparam int PERIOD_W    = 31;
  localparam int SLOT_W      = 4;
  localparam int MASK_W      = 10;
  localparam int CNT_W       = $clog2(NUM_SLOTS + 1);
  localparam int MASK_PAD_W  = (NUM_SLOTS > MASK_W) ? NUM_SLOTS : MASK_W;
  localparam int SLOT_PAD_W  = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  localparam logic REQ_REGISTER = 1'b0;
  localparam logic REQ_TICK     = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_FULL  = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [PERIOD_W-1:0] period_ms;
  } in_t;

  typedef struct packed {
    logic              reg_status;
    logic [SLOT_W-1:0] reg_slot;
    logic [MASK_W-1:0] fire_mask;
  } out_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic                wr;
    logic [PERIOD_W-1:0] period;
    logic [TICK_W-1:0]   tick;
  } cell_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/pstsch_cell.sv
// One timer slot of the scheduler chain: period, last tick and started flag.
// Depends on pstsch_pkg for cell_cmd_t and field widths.
`default_nettype none

module pstsch_cell (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire pstsch_pkg::cell_cmd_t cmd_i,
  input  wire logic                  sel_i,
  input  wire logic                  visit_i,
  output logic                       visit_o,
  output logic                       fire_o
);

  logic                          used_q, used_d;
  logic                          started_q, started_d;
  logic [pstsch_pkg::PERIOD_W-1:0] period_q, period_d;
  logic [pstsch_pkg::TICK_W-1:0]   last_q, last_d;
  logic                          visit_q;
  logic [pstsch_pkg::TICK_W-1:0]   due;

  assign due = last_q + pstsch_pkg::TICK_W'(period_q);

  always_comb begin
    used_d    = used_q;
    started_d = started_q;
    period_d  = period_q;
    last_d    = last_q;
    fire_o    = 1'b0;
    if (cmd_i.wr && sel_i) begin
      used_d    = 1'b1;
      started_d = 1'b0;
      period_d  = cmd_i.period;
      last_d    = '0;
    end else if (visit_i && used_q) begin
      if (!started_q) begin
        // first visit: record the tick, no fire
        started_d = 1'b1;
        last_d    = cmd_i.tick;
      end else if (period_q != '0 && due == cmd_i.tick) begin
        fire_o = 1'b1;
        last_d = cmd_i.tick;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= 1'b0;
      started_q <= 1'b0;
      visit_q   <= 1'b0;
    end else begin
      used_q    <= used_d;
      started_q <= started_d;
      visit_q   <= visit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    period_q <= period_d;
    last_q   <= last_d;
  end

  assign visit_o = visit_q;

endmodule

`default_nettype wire

>>> rtl/core/periodic_slot_tick_scheduler_core.sv
// Top level of the periodic slot tick scheduler: tick counter, slot fill
// count, and a chain of pstsch_cell instances. Depends on pstsch_pkg.
`default_nettype none

// A beat is taken when start is high and busy is low. A register beat
// answers in the next cycle; a tick beat sends a visit token down the chain
// of NUM_SLOTS cells, one cell per cycle, and answers and drops busy once
// the token has left the last cell. Each answer is on res_o for one
// cycle while res_valid_o is high and cannot be held off by the receiver.
module periodic_slot_tick_scheduler_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire pstsch_pkg::in_t  req_i,
  output logic                  busy,
  output logic                  res_valid_o,
  output pstsch_pkg::out_t      res_o
);

  localparam int N = pstsch_pkg::NUM_SLOTS;

  logic                          accept;
  logic [pstsch_pkg::TICK_W-1:0] tick_q, tick_d;
  logic [pstsch_pkg::CNT_W-1:0]  used_q, used_d;
  logic                          go_q, go_d;
  logic [N-1:0]                  mask_q, mask_d;
  logic                          full;
  logic                          valid_q, valid_d;
  pstsch_pkg::out_t              res_q, res_d;
  pstsch_pkg::cell_cmd_t         cmd;
  logic [N:0]                    visit;
  logic [N-1:0]                  fire;
  logic [pstsch_pkg::MASK_PAD_W-1:0] mask_pad;
  logic [pstsch_pkg::SLOT_PAD_W-1:0] slot_pad;

  assign accept = start && !busy;
  assign busy   = go_q || (|visit[N:1]);
  assign full   = (used_q >= pstsch_pkg::CNT_W'(N));

  assign cmd.wr     = accept && (req_i.req_type == pstsch_pkg::REQ_REGISTER) && !full;
  assign cmd.period = req_i.period_ms;
  assign cmd.tick   = tick_q;

  assign visit[0] = go_q;

  for (genvar i = 0; i < N; i++) begin : g_cell
    pstsch_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .sel_i   (used_q == pstsch_pkg::CNT_W'(i)),
      .visit_i (visit[i]),
      .visit_o (visit[i+1]),
      .fire_o  (fire[i])
    );
  end

  assign mask_pad = pstsch_pkg::MASK_PAD_W'(mask_d);
  assign slot_pad = pstsch_pkg::SLOT_PAD_W'(used_q);

  always_comb begin
    tick_d  = tick_q;
    used_d  = used_q;
    go_d    = 1'b0;
    mask_d  = mask_q | fire;
    valid_d = 1'b0;
    res_d   = res_q;
    if (accept) begin
      if (req_i.req_type == pstsch_pkg::REQ_TICK) begin
        // advance the counter, then launch the visit token
        tick_d = tick_q + 1'b1;
        go_d   = 1'b1;
        mask_d = '0;
      end else begin
        valid_d          = 1'b1;
        res_d.fire_mask  = '0;
        if (full) begin
          res_d.reg_status = pstsch_pkg::STATUS_FULL;
          res_d.reg_slot   = '0;
        end else begin
          res_d.reg_status = pstsch_pkg::STATUS_OK;
          res_d.reg_slot   = slot_pad[pstsch_pkg::SLOT_W-1:0];
          used_d           = used_q + 1'b1;
        end
      end
    end else if (visit[N]) begin
      // token left the last cell: mask is complete
      valid_d          = 1'b1;
      res_d.reg_status = pstsch_pkg::STATUS_OK;
      res_d.reg_slot   = '0;
      res_d.fire_mask  = mask_pad[pstsch_pkg::MASK_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      used_q  <= '0;
      go_q    <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      tick_q  <= tick_d;
      used_q  <= used_d;
      go_q    <= go_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    res_q  <= res_d;
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking bench for periodic_slot_tick_scheduler_core: a directed table,
// then random register and tick beats checked against a local slot-table predictor.
// Depends on pstsch_pkg and the core RTL.
`timescale 1ns / 100ps

module testbench;

  localparam int RANDOM_BEATS = 600;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = pstsch_pkg::NUM_SLOTS + 6;

  typedef struct {
    pstsch_pkg::in_t  beat;
    bit               known;
    pstsch_pkg::out_t want;
  } plan_row_t;

  logic             clk_i  = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start  = 1'b0;
  pstsch_pkg::in_t  req_i  = '0;
  logic             busy;
  logic             res_valid_o;
  pstsch_pkg::out_t res_o;

  // Slot-table predictor state.
  logic [pstsch_pkg::TICK_W-1:0] tick_now = '0;
  int                            used_cnt = 0;
  logic [pstsch_pkg::TICK_W-1:0] per_tbl  [pstsch_pkg::NUM_SLOTS];
  logic [pstsch_pkg::TICK_W-1:0] last_tbl [pstsch_pkg::NUM_SLOTS];
  bit                            started_tbl [pstsch_pkg::NUM_SLOTS] = '{default: 1'b0};

  pstsch_pkg::out_t answers_pending[$];
  plan_row_t        plan[$];
  bit               typed_now = 1'b0;
  pstsch_pkg::out_t typed_want = '0;
  pstsch_pkg::out_t got_ans;
  pstsch_pkg::out_t exp_ans;
  bit               failed = 1'b0;
  int unsigned      cycles = 0;
  pstsch_pkg::in_t  rnd_beat;
  int               k;

  periodic_slot_tick_scheduler_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_i       (req_i),
    .busy        (busy),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic pstsch_pkg::out_t next_answer(pstsch_pkg::in_t rq);
    pstsch_pkg::out_t a;
    int               i;
    a = '0;
    if (rq.req_type == pstsch_pkg::REQ_REGISTER) begin
      if (used_cnt >= pstsch_pkg::NUM_SLOTS) begin
        a.reg_status = pstsch_pkg::STATUS_FULL;
      end else begin
        per_tbl[used_cnt]     = {1'b0, rq.period_ms};
        last_tbl[used_cnt]    = '0;
        started_tbl[used_cnt] = 1'b0;
        a.reg_status          = pstsch_pkg::STATUS_OK;
        a.reg_slot            = pstsch_pkg::SLOT_W'(used_cnt);
        used_cnt++;
      end
    end else begin
      tick_now = tick_now + 1'b1;
      for (i = 0; i < used_cnt; i++) begin
        // First visit only records the counter.
        if (!started_tbl[i]) begin
          started_tbl[i] = 1'b1;
          last_tbl[i]    = tick_now;
        end else if (per_tbl[i] != '0 &&
                     pstsch_pkg::TICK_W'(last_tbl[i] + per_tbl[i]) == tick_now) begin
          a.fire_mask[i] = 1'b1;
          last_tbl[i]    = tick_now;
        end
      end
    end
    return a;
  endfunction

  function automatic int pick_gap(int idx);
    int r;
    // Hold start high through some stretches.
    if ((idx / 40) % 4 == 2) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(12, 45);
  endfunction

  task automatic add_row(input logic rt, input logic [pstsch_pkg::PERIOD_W-1:0] per,
                         input bit known, input logic st, input int sl, input int mk);
    plan_row_t row;
    row.beat.req_type   = rt;
    row.beat.period_ms  = per;
    row.known           = known;
    row.want.reg_status = st;
    row.want.reg_slot   = pstsch_pkg::SLOT_W'(sl);
    row.want.fire_mask  = pstsch_pkg::MASK_W'(mk);
    plan.push_back(row);
  endtask

  task automatic send_beat(input pstsch_pkg::in_t b, input bit known,
                           input pstsch_pkg::out_t want, input int gap);
    repeat (gap) begin
      @(negedge clk_i);
      start = 1'b0;
    end
    @(negedge clk_i);
    start      = 1'b1;
    req_i      = b;
    typed_now  = known;
    typed_want = want;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  // Take accepted beats into the predictor, then check any answer on the bus.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start === 1'b1 && busy === 1'b0) begin
        exp_ans = next_answer(req_i);
        answers_pending.push_back(typed_now ? typed_want : exp_ans);
      end
      if (res_valid_o === 1'b1) begin
        got_ans = res_o;
        if (answers_pending.size() == 0) begin
          $error("unexpected answer: status %0d slot %0d mask %03h",
                 got_ans.reg_status, got_ans.reg_slot, got_ans.fire_mask);
          failed = 1'b1;
        end else begin
          exp_ans = answers_pending.pop_front();
          if (got_ans.reg_status !== exp_ans.reg_status) begin
            $error("reg_status: expected %0d, got %0d", exp_ans.reg_status, got_ans.reg_status);
            failed = 1'b1;
          end
          if (got_ans.reg_slot !== exp_ans.reg_slot) begin
            $error("reg_slot: expected %0d, got %0d", exp_ans.reg_slot, got_ans.reg_slot);
            failed = 1'b1;
          end
          if (got_ans.fire_mask !== exp_ans.fire_mask) begin
            $error("fire_mask: expected %03h, got %03h", exp_ans.fire_mask, got_ans.fire_mask);
            failed = 1'b1;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    // Tick with an empty table, then fill all slots, including zero and max period.
    add_row(pstsch_pkg::REQ_TICK,     31'h0,        1, pstsch_pkg::STATUS_OK,   0, 0);
    add_row(pstsch_pkg::REQ_REGISTER, 31'h0,        1, pstsch_pkg::STATUS_OK,   0, 0);
    add_row(pstsch_pkg::REQ_REGISTER, 31'h7FFFFFFF, 1, pstsch_pkg::STATUS_OK,   1, 0);
    add_row(pstsch_pkg::REQ_REGISTER, 31'h1,        1, pstsch_pkg::STATUS_OK,   2, 0);
    add_row(pstsch_pkg::REQ_TICK,     31'h0,        1, pstsch_pkg::STATUS_OK,   0, 0);
    add_row(pstsch_pkg::REQ_TICK,     31'h0,        0, pstsch_pkg::STATUS_OK,   0, 0);
    add_row(pstsch_pkg::REQ_TICK,     31'h0,        0, pstsch_pkg::STATUS_OK,   0, 0);
    add_row(pstsch_pkg::REQ_REGISTER, 31'h2,        1, pstsch_pkg::STATUS_OK,   3, 0);
    add_row(pstsch_pkg::REQ_REGISTER, 31'h3,        1, pstsch_pkg::STATUS_OK,   4, 0);
    add_row(pstsch_pkg::REQ_TICK,     31'h0,        0, pstsch_pkg::STATUS_OK,   0, 0);
    add_row(pstsch_pkg::REQ_TICK,     31'h0,        0, pstsch_pkg::STATUS_OK,   0, 0);
    add_row(pstsch_pkg::REQ_TICK,     31'h0,        0, pstsch_pkg::STATUS_OK,   0, 0);
    add_row(pstsch_pkg::REQ_REGISTER, 31'h5,        1, pstsch_pkg::STATUS_OK,   5, 0);
    add_row(pstsch_pkg::REQ_REGISTER, 31'h7,        1, pstsch_pkg::STATUS_OK,   6, 0);
    add_row(pstsch_pkg::REQ_REGISTER, 31'hC,        1, pstsch_pkg::STATUS_OK,   7, 0);
    add_row(pstsch_pkg::REQ_REGISTER, 31'h2AAAAAAA, 1, pstsch_pkg::STATUS_OK,   8, 0);
    add_row(pstsch_pkg::REQ_REGISTER, 31'h4,        1, pstsch_pkg::STATUS_OK,   9, 0);
    // Table full: nothing stored.
    add_row(pstsch_pkg::REQ_REGISTER, 31'h55555555, 1, pstsch_pkg::STATUS_FULL, 0, 0);
    add_row(pstsch_pkg::REQ_REGISTER, 31'h0,        1, pstsch_pkg::STATUS_FULL, 0, 0);
    add_row(pstsch_pkg::REQ_TICK,     31'h0,        0, pstsch_pkg::STATUS_OK,   0, 0);
    add_row(pstsch_pkg::REQ_TICK,     31'h0,        0, pstsch_pkg::STATUS_OK,   0, 0);
    add_row(pstsch_pkg::REQ_TICK,     31'h7FFFFFFF, 0, pstsch_pkg::STATUS_OK,   0, 0);
    add_row(pstsch_pkg::REQ_TICK,     31'h0,        0, pstsch_pkg::STATUS_OK,   0, 0);
    add_row(pstsch_pkg::REQ_TICK,     31'h0,        0, pstsch_pkg::STATUS_OK,   0, 0);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (k = 0; k < plan.size(); k++) begin
      send_beat(plan[k].beat, plan[k].known, plan[k].want, k % 3);
    end

    for (k = 0; k < RANDOM_BEATS; k++) begin
      rnd_beat.req_type  = ($urandom_range(0, 99) < 80) ? pstsch_pkg::REQ_TICK
                                                        : pstsch_pkg::REQ_REGISTER;
      rnd_beat.period_ms = pstsch_pkg::PERIOD_W'($urandom());
      send_beat(rnd_beat, 1'b0, '0, pick_gap(k));
    end

    @(negedge clk_i);
    start = 1'b0;
    while (answers_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (!failed) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
